FILE: hdl/i2cbb_pkg.sv
`default_nettype none
package i2cbb_pkg;

   // Command codes carried in the operation field; codes above RECEIVE mean tick only.
   typedef enum logic [2:0] {
      CMD_IDLE     = 3'd0,
      CMD_START    = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_TRANSMIT = 3'd3,
      CMD_RECEIVE  = 3'd4
   } cmd_type;

   localparam int unsigned STEP_W     = 5;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;

   // Step numbers of the fixed parts of each sequence.
   localparam logic [STEP_W-1:0] STEP_BUS_LAST  = 5'd3;
   localparam logic [STEP_W-1:0] STEP_TX_ACK_SDA = 5'd24;
   localparam logic [STEP_W-1:0] STEP_TX_ACK_SCL = 5'd25;
   localparam logic [STEP_W-1:0] STEP_RX_BIT_END = 5'd16;
   localparam logic [STEP_W-1:0] STEP_RX_ACK_SDA = 5'd17;
   localparam logic [STEP_W-1:0] STEP_RX_ACK_SCL = 5'd18;

   // Bit phases of one transmitted bit.
   localparam logic [1:0] PHASE_SET_SDA  = 2'd0;
   localparam logic [1:0] PHASE_SCL_HIGH = 2'd1;
   localparam logic [1:0] PHASE_SCL_LOW  = 2'd2;

   localparam logic [7:0] MSB_MASK = 8'h80;

   typedef struct packed {
      logic       sda_in;
      logic       send_ack;
      logic [7:0] tx_byte;
      logic [2:0] operation;
   } req_item_type;

   typedef struct packed {
      logic       ack_seen;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_release;
      logic       scl_release;
   } rsp_item_type;

   typedef struct packed {
      logic              scl_level;
      logic              sda_level;
      logic [STEP_W-1:0] step_count;
      logic [1:0]        bit_phase;
      cmd_type           active_command;
      logic [7:0]        shift_reg;
      logic              ack_flag;
      logic              ack_request;
      logic [7:0]        rx_hold;
   } bus_state_type;

endpackage
`default_nettype wire

FILE: hdl/i2c_bitbang_master_core.sv
`default_nettype none
// Channel  Ports                        Payload (lowest bit first)
// req      req_tvalid/tready/tdata      operation[2:0], tx_byte[7:0], send_ack, sda_in
// rsp      rsp_tvalid/tready/tdata      scl_release, sda_release, busy_res, done_res,
//                                       rx_byte[7:0], ack_seen
//
// Each accepted tick waits in the input register, then yields one registered result.
// One tick is accepted per cycle while results are taken; the bus sequencer steps once
// per tick, so a start or stop takes 4 ticks, a transmit 27 and a receive 20.
// Reset releases both lines and returns the sequencer to idle.
// A stalled result holds the held request in the input register, which then stalls req.
module i2c_bitbang_master_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // operation[2:0], tx_byte[10:3], send_ack[11], sda_in[12]
   input  wire  [i2cbb_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // scl_release[0], sda_release[1], busy_res[2], done_res[3], rx_byte[11:4], ack_seen[12]
   output logic [i2cbb_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   i2cbb_pkg::req_item_type  req_item;
   i2cbb_pkg::req_item_type  held_item;
   logic                     held_valid;
   logic                     advance;
   i2cbb_pkg::bus_state_type state_ff;
   i2cbb_pkg::bus_state_type state_in;
   i2cbb_pkg::rsp_item_type  step_rsp;
   i2cbb_pkg::rsp_item_type  rsp_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;

   assign req_item = req_tdata[12:0];

   // The held tick is processed once the result register is free or being emptied.
   assign advance = held_valid && (!rsp_valid_ff || rsp_tready);

   i2cbb_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .held_valid (held_valid),
      .held_take  (advance),
      .held_item  (held_item)
   );

   i2cbb_step u_step (
      .item (held_item),
      .cur  (state_ff),
      .nxt  (state_in),
      .rsp  (step_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff            <= 1'b0;
         state_ff.scl_level      <= 1'b1;
         state_ff.sda_level      <= 1'b1;
         state_ff.step_count     <= '0;
         state_ff.bit_phase      <= i2cbb_pkg::PHASE_SET_SDA;
         state_ff.active_command <= i2cbb_pkg::CMD_IDLE;
         state_ff.shift_reg      <= '0;
         state_ff.ack_flag       <= 1'b0;
         state_ff.ack_request    <= 1'b0;
         state_ff.rx_hold        <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff};

`ifndef NO_ASSERTIONS
   a_idle_step_zero : assert property (@(posedge clock) disable iff (reset)
      state_ff.active_command == i2cbb_pkg::CMD_IDLE |->
         state_ff.step_count == '0 && state_ff.bit_phase == i2cbb_pkg::PHASE_SET_SDA)
      else $error("idle sequencer holds a nonzero step");

   a_phase_range : assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_phase != 2'd3)
      else $error("bit phase out of range");

   a_done_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> rsp_ff.busy_res)
      else $error("done reported without a step");

   a_step_advance : assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.active_command != i2cbb_pkg::CMD_IDLE && !step_rsp.done_res |=>
         state_ff.step_count == $past(state_ff.step_count) + 5'd1)
      else $error("sequencer step did not advance");

   a_stall_holds_state : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("bus state changed without a tick");
`endif

endmodule
`default_nettype wire

FILE: hdl/i2cbb_in_reg.sv
`default_nettype none
module i2cbb_in_reg (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire i2cbb_pkg::req_item_type in_item,
   output logic                         held_valid,
   input  wire                          held_take,
   output i2cbb_pkg::req_item_type      held_item
);

   logic                    valid_ff;
   logic                    valid_in;
   i2cbb_pkg::req_item_type item_ff;

   // A new transaction may enter while the register is empty or the held one leaves in the same cycle.
   assign in_ready   = !valid_ff || held_take;
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/i2cbb_step.sv
`default_nettype none
module i2cbb_step (
   input  wire i2cbb_pkg::req_item_type  item,
   input  wire i2cbb_pkg::bus_state_type cur,
   output i2cbb_pkg::bus_state_type      nxt,
   output i2cbb_pkg::rsp_item_type       rsp
);

   i2cbb_pkg::bus_state_type st;
   logic                     last_step;
   logic                     busy;
   logic [2:0]               op;

   always_comb begin
      st        = cur;
      last_step = 1'b0;
      busy      = 1'b0;
      op        = item.operation;

      // Commands are taken only while idle; unknown codes are plain ticks.
      if (cur.active_command == i2cbb_pkg::CMD_IDLE &&
          op >= 3'(i2cbb_pkg::CMD_START) && op <= 3'(i2cbb_pkg::CMD_RECEIVE)) begin
         st.active_command = i2cbb_pkg::cmd_type'(op);
         st.step_count     = '0;
         st.bit_phase      = i2cbb_pkg::PHASE_SET_SDA;
         if (op == 3'(i2cbb_pkg::CMD_TRANSMIT)) begin
            st.shift_reg = item.tx_byte;
         end else if (op == 3'(i2cbb_pkg::CMD_RECEIVE)) begin
            st.shift_reg   = '0;
            st.ack_request = item.send_ack;
         end
      end

      case (st.active_command)
         i2cbb_pkg::CMD_START: begin
            busy = 1'b1;
            case (st.step_count)
               5'd0:    st.sda_level = 1'b1;
               5'd1:    st.scl_level = 1'b1;
               5'd2:    st.sda_level = 1'b0;
               default: st.scl_level = 1'b0;
            endcase
            last_step = st.step_count >= i2cbb_pkg::STEP_BUS_LAST;
         end
         i2cbb_pkg::CMD_STOP: begin
            busy = 1'b1;
            case (st.step_count)
               5'd0:    st.scl_level = 1'b0;
               5'd1:    st.sda_level = 1'b0;
               5'd2:    st.scl_level = 1'b1;
               default: st.sda_level = 1'b1;
            endcase
            last_step = st.step_count >= i2cbb_pkg::STEP_BUS_LAST;
         end
         i2cbb_pkg::CMD_TRANSMIT: begin
            busy = 1'b1;
            if (st.step_count < i2cbb_pkg::STEP_TX_ACK_SDA) begin
               case (st.bit_phase)
                  i2cbb_pkg::PHASE_SET_SDA:
                     st.sda_level = |(st.shift_reg & i2cbb_pkg::MSB_MASK);
                  i2cbb_pkg::PHASE_SCL_HIGH:
                     st.scl_level = 1'b1;
                  default: begin
                     st.scl_level = 1'b0;
                     st.shift_reg = {st.shift_reg[6:0], 1'b0};
                  end
               endcase
            end else if (st.step_count == i2cbb_pkg::STEP_TX_ACK_SDA) begin
               st.sda_level = 1'b1;
            end else if (st.step_count == i2cbb_pkg::STEP_TX_ACK_SCL) begin
               st.scl_level = 1'b1;
               st.ack_flag  = !item.sda_in;
            end else begin
               st.scl_level = 1'b0;
               last_step    = 1'b1;
            end
         end
         i2cbb_pkg::CMD_RECEIVE: begin
            busy = 1'b1;
            if (st.step_count == '0) begin
               st.sda_level = 1'b1;
            end else if (st.step_count <= i2cbb_pkg::STEP_RX_BIT_END) begin
               if (st.step_count[0]) begin
                  st.scl_level = 1'b1;
                  st.shift_reg = {st.shift_reg[6:0], item.sda_in};
               end else begin
                  st.scl_level = 1'b0;
               end
            end else if (st.step_count == i2cbb_pkg::STEP_RX_ACK_SDA) begin
               st.sda_level = !st.ack_request;
            end else if (st.step_count == i2cbb_pkg::STEP_RX_ACK_SCL) begin
               st.scl_level = 1'b1;
            end else begin
               st.scl_level = 1'b0;
               st.rx_hold   = st.shift_reg;
               last_step    = 1'b1;
            end
         end
         default: begin
            busy = 1'b0;
         end
      endcase

      if (busy) begin
         if (last_step) begin
            st.active_command = i2cbb_pkg::CMD_IDLE;
            st.step_count     = '0;
            st.bit_phase      = i2cbb_pkg::PHASE_SET_SDA;
         end else begin
            st.step_count = st.step_count + 5'd1;
            st.bit_phase  = (st.bit_phase == i2cbb_pkg::PHASE_SCL_LOW) ?
                            i2cbb_pkg::PHASE_SET_SDA : st.bit_phase + 2'd1;
         end
      end

      nxt             = st;
      rsp.scl_release = st.scl_level;
      rsp.sda_release = st.sda_level;
      rsp.busy_res    = busy;
      rsp.done_res    = busy && last_step;
      rsp.rx_byte     = st.rx_hold;
      rsp.ack_seen    = st.ack_flag;
   end

endmodule
`default_nettype wire

FILE: dv/tb.sv
module tb;

   // Step numbers of the fixed parts of each bus sequence.
   localparam int BUS_LAST_STEP   = 3;
   localparam int TX_ACK_SDA_STEP = 24;
   localparam int TX_ACK_SCL_STEP = 25;
   localparam int RX_BITS_END     = 16;
   localparam int RX_ACK_SDA_STEP = 17;
   localparam int RX_ACK_SCL_STEP = 18;

   // Codes above receive carry no command.
   localparam logic [2:0] OP_SPARE_LOW = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_CODE_MAX  = 3'd7;
   localparam int SDA_LOW    = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_RANDOM = 2;

   localparam int TICK_TARGET  = 1700;
   localparam int QUIET_LIMIT  = 2000;
   localparam int REPORT_LIMIT = 10;

   class bus_step_scoreboard;
      logic                    scl;
      logic                    sda;
      logic [4:0]              step;
      i2cbb_pkg::cmd_type      cmd;
      logic [7:0]              shifter;
      logic                    ack_flag;
      logic                    ack_req;
      logic [7:0]              held_byte;
      i2cbb_pkg::rsp_item_type expected_pins[$];
      int                      errors;
      int                      stepped;
      int                      checked;
      int                      finished[5];

      function new();
         scl = 1'b1;
         sda = 1'b1;
         step = '0;
         cmd = i2cbb_pkg::CMD_IDLE;
         shifter = '0;
         ack_flag = 1'b0;
         ack_req = 1'b0;
         held_byte = '0;
         errors = 0;
         stepped = 0;
         checked = 0;
         foreach (finished[i]) finished[i] = 0;
      endfunction

      function bit idle();
         return cmd == i2cbb_pkg::CMD_IDLE;
      endfunction

      function int pending();
         return expected_pins.size();
      endfunction

      function int total_faults();
         return errors + expected_pins.size();
      endfunction

      // Works out the pin levels that one accepted tick must produce.
      function void note_tick(i2cbb_pkg::req_item_type r);
         i2cbb_pkg::rsp_item_type e;
         logic                    last;
         logic                    busy;
         last = 1'b0;
         busy = 1'b0;
         if (cmd == i2cbb_pkg::CMD_IDLE && r.operation >= i2cbb_pkg::CMD_START &&
             r.operation <= i2cbb_pkg::CMD_RECEIVE) begin
            cmd = i2cbb_pkg::cmd_type'(r.operation);
            step = '0;
            if (cmd == i2cbb_pkg::CMD_TRANSMIT) begin
               shifter = r.tx_byte;
            end else if (cmd == i2cbb_pkg::CMD_RECEIVE) begin
               shifter = '0;
               ack_req = r.send_ack;
            end
         end
         if (cmd != i2cbb_pkg::CMD_IDLE) begin
            case (cmd)
               i2cbb_pkg::CMD_START: begin
                  case (step)
                     5'd0: sda = 1'b1;
                     5'd1: scl = 1'b1;
                     5'd2: sda = 1'b0;
                     default: scl = 1'b0;
                  endcase
                  last = (step >= BUS_LAST_STEP);
               end
               i2cbb_pkg::CMD_STOP: begin
                  case (step)
                     5'd0: scl = 1'b0;
                     5'd1: sda = 1'b0;
                     5'd2: scl = 1'b1;
                     default: sda = 1'b1;
                  endcase
                  last = (step >= BUS_LAST_STEP);
               end
               i2cbb_pkg::CMD_TRANSMIT: begin
                  if (step < TX_ACK_SDA_STEP) begin
                     // Each data bit takes three steps: drive SDA, raise SCL, drop SCL.
                     case (step % 3)
                        0: sda = shifter[7];
                        1: scl = 1'b1;
                        default: begin
                           scl = 1'b0;
                           shifter = {shifter[6:0], 1'b0};
                        end
                     endcase
                  end else if (step == TX_ACK_SDA_STEP) begin
                     sda = 1'b1;
                  end else if (step == TX_ACK_SCL_STEP) begin
                     scl = 1'b1;
                     ack_flag = !r.sda_in;
                  end else begin
                     scl = 1'b0;
                     last = 1'b1;
                  end
               end
               default: begin
                  if (step == 0) begin
                     sda = 1'b1;
                  end else if (step <= RX_BITS_END) begin
                     if (step[0]) begin
                        scl = 1'b1;
                        shifter = {shifter[6:0], r.sda_in};
                     end else begin
                        scl = 1'b0;
                     end
                  end else if (step == RX_ACK_SDA_STEP) begin
                     sda = !ack_req;
                  end else if (step == RX_ACK_SCL_STEP) begin
                     scl = 1'b1;
                  end else begin
                     scl = 1'b0;
                     held_byte = shifter;
                     last = 1'b1;
                  end
               end
            endcase
            busy = 1'b1;
            stepped++;
            if (last) begin
               finished[cmd]++;
               cmd = i2cbb_pkg::CMD_IDLE;
               step = '0;
            end else begin
               step = step + 5'd1;
            end
         end
         e.scl_release = scl;
         e.sda_release = sda;
         e.busy_res = busy;
         e.done_res = last;
         e.rx_byte = held_byte;
         e.ack_seen = ack_flag;
         expected_pins.push_back(e);
      endfunction

      function void flag(string what, int unsigned want, int unsigned got);
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("tb: result %0d %s mismatch: expected 0x%0h, got 0x%0h",
                     checked, what, want, got);
      endfunction

      function void check_pins(logic [15:0] data);
         i2cbb_pkg::rsp_item_type a;
         i2cbb_pkg::rsp_item_type e;
         a = data[12:0];
         if (expected_pins.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("tb: result 0x%0h arrived with nothing expected", data);
            return;
         end
         e = expected_pins.pop_front();
         if (a.scl_release !== e.scl_release) flag("scl_release", e.scl_release, a.scl_release);
         if (a.sda_release !== e.sda_release) flag("sda_release", e.sda_release, a.sda_release);
         if (a.busy_res !== e.busy_res) flag("busy_res", e.busy_res, a.busy_res);
         if (a.done_res !== e.done_res) flag("done_res", e.done_res, a.done_res);
         if (a.rx_byte !== e.rx_byte) flag("rx_byte", e.rx_byte, a.rx_byte);
         if (a.ack_seen !== e.ack_seen) flag("ack_seen", e.ack_seen, a.ack_seen);
         checked++;
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [15:0] rsp_tdata;

   bus_step_scoreboard ledger = new();
   int gap_pct = 0;
   int stall_pct = 0;
   int quiet = 0;

   i2c_bitbang_master_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_pins(rsp_tdata);
   end

   // Ends the run if the handshakes stop moving.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("tb: no transaction for %0d cycles", QUIET_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic drive_tick(i2cbb_pkg::req_item_type item);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, item};
      do @(posedge clock); while (!req_tready);
      ledger.note_tick(item);
   endtask

   // Issues one command, then keeps ticking until the sequencer is idle again.
   // While it runs, ticks may carry commands that must be ignored.
   task automatic run_command(logic [2:0] op, logic [7:0] data, logic ack_bit,
                              int sda_sel, int meddle_pct);
      i2cbb_pkg::req_item_type item;
      item.operation = op;
      item.tx_byte = data;
      item.send_ack = ack_bit;
      forever begin
         item.sda_in = (sda_sel == SDA_RANDOM) ? 1'($urandom) : sda_sel[0];
         drive_tick(item);
         if (ledger.idle()) break;
         item.operation = ($urandom_range(99) < meddle_pct) ?
                          3'($urandom_range(OP_CODE_MAX)) : i2cbb_pkg::CMD_IDLE;
         item.tx_byte = 8'($urandom);
         item.send_ack = 1'($urandom);
      end
   endtask

   initial begin
      int phase;
      int count;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: unused codes at idle, full frames with extreme bytes, fixed acks,
      // commands during a running sequence, a stop with no start and a repeated start.
      run_command(i2cbb_pkg::CMD_IDLE, 8'h00, 1'b0, SDA_LOW, 0);
      run_command(OP_SPARE_LOW, 8'hFF, 1'b1, SDA_HIGH, 0);
      run_command(OP_SPARE_MID, 8'h00, 1'b0, SDA_LOW, 0);
      run_command(OP_CODE_MAX, 8'hFF, 1'b1, SDA_HIGH, 0);
      run_command(i2cbb_pkg::CMD_START, 8'h00, 1'b0, SDA_HIGH, 0);
      run_command(i2cbb_pkg::CMD_TRANSMIT, 8'hFF, 1'b0, SDA_LOW, 0);
      run_command(i2cbb_pkg::CMD_TRANSMIT, 8'h00, 1'b1, SDA_HIGH, 0);
      run_command(i2cbb_pkg::CMD_TRANSMIT, 8'hA5, 1'b0, SDA_RANDOM, 100);
      run_command(i2cbb_pkg::CMD_RECEIVE, 8'h00, 1'b1, SDA_HIGH, 0);
      run_command(i2cbb_pkg::CMD_RECEIVE, 8'hFF, 1'b0, SDA_LOW, 0);
      run_command(i2cbb_pkg::CMD_RECEIVE, 8'h5A, 1'b1, SDA_RANDOM, 100);
      run_command(i2cbb_pkg::CMD_START, 8'h00, 1'b0, SDA_RANDOM, 100);
      run_command(i2cbb_pkg::CMD_START, 8'hFF, 1'b1, SDA_LOW, 0);
      run_command(i2cbb_pkg::CMD_STOP, 8'h00, 1'b0, SDA_HIGH, 100);
      run_command(i2cbb_pkg::CMD_STOP, 8'hFF, 1'b1, SDA_LOW, 0);

      // Random: mostly complete frames, some stray commands, across four idling phases.
      while (ledger.stepped < TICK_TARGET) begin
         phase = ledger.stepped * 4 / TICK_TARGET;
         case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 70; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 70; end
            default: begin gap_pct = 10; stall_pct = 10; end
         endcase
         if ($urandom_range(99) < 80) begin
            run_command(i2cbb_pkg::CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 5);
            count = $urandom_range(1, 4);
            repeat (count) begin
               if ($urandom_range(1))
                  run_command(i2cbb_pkg::CMD_TRANSMIT, 8'($urandom), 1'($urandom),
                              SDA_RANDOM, 5);
               else
                  run_command(i2cbb_pkg::CMD_RECEIVE, 8'($urandom), 1'($urandom),
                              SDA_RANDOM, 5);
            end
            if ($urandom_range(9) != 0)
               run_command(i2cbb_pkg::CMD_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 5);
         end else begin
            run_command(3'($urandom_range(OP_CODE_MAX)), 8'($urandom), 1'($urandom),
                        SDA_RANDOM, 30);
         end
      end
      req_tvalid <= 1'b0;

      while (ledger.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("tb: %0d results checked, %0d ticks stepped the bus sequencer",
               ledger.checked, ledger.stepped);
      $display("tb: finished %0d starts, %0d stops, %0d transmits, %0d receives",
               ledger.finished[i2cbb_pkg::CMD_START], ledger.finished[i2cbb_pkg::CMD_STOP],
               ledger.finished[i2cbb_pkg::CMD_TRANSMIT],
               ledger.finished[i2cbb_pkg::CMD_RECEIVE]);
      if (ledger.total_faults() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d mismatches", ledger.total_faults());
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/i2cbb_pkg.sv
hdl/i2cbb_in_reg.sv
hdl/i2cbb_step.sv
hdl/i2c_bitbang_master_core.sv
dv/tb.sv
